### rtl/assert_macros.svh
// Assertion helpers shared by the loader RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define MWL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define MWL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/mwl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Microwire EEPROM loader package
// Shared types, constants and helpers for the loader sequencer and top level.
// ----------------------------------------------------------------------------
package mwl_pkg;

  localparam int DEF_WORD_COUNT    = 64;
  localparam int DEF_MAX_ADDR_BITS = 8;

  localparam int WORD_W    = 16;
  localparam int INDEX_W   = 6;
  localparam int ABITS_W   = 4;
  localparam int BIT_CNT_W = 5;

  localparam logic [WORD_W-1:0] CHECKSUM_RESET = 16'hBABA;

  // Last opcode bit position (opcode is three bits: 1,1,0)
  localparam logic [BIT_CNT_W-1:0] OPCODE_LAST = 5'd2;
  localparam logic [BIT_CNT_W-1:0] DATA_LAST   = 5'd15;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SZ_OP,
    PH_SZ_ADDR,
    PH_GAP,
    PH_RD_OP,
    PH_RD_ADDR,
    PH_RD_DATA
  } phase_t;

  typedef struct packed {
    logic [ABITS_W-1:0] address_bits;
    logic               checksum_ok;
    logic               done_res;
    logic [WORD_W-1:0]  word_value;
    logic [INDEX_W-1:0] word_index;
    logic               word_valid;
    logic               data_in_bit;
    logic               chip_select;
  } result_t;

  // READ opcode bit k, sent first to last
  function automatic logic opcode_bit(input logic [BIT_CNT_W-1:0] k);
    return (k < 5'd2);
  endfunction

endpackage

### rtl/mwl_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Microwire EEPROM loader sequencer
// Serial-period state machine: sizes the address, then reads every word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mwl_seq #(
  parameter int WORD_COUNT    = mwl_pkg::DEF_WORD_COUNT,
  parameter int MAX_ADDR_BITS = mwl_pkg::DEF_MAX_ADDR_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          start_req,
  input  logic                          data_out_bit,
  input  logic [mwl_pkg::WORD_W-1:0]    checksum_target,
  output mwl_pkg::result_t              res
);
  import mwl_pkg::*;

  localparam int WA_W = $clog2(WORD_COUNT + 1);
  localparam int AW_W = $clog2(MAX_ADDR_BITS + 1);

  phase_t               phase, phase_next;
  logic [BIT_CNT_W-1:0] bit_count, bit_count_next;
  logic [AW_W-1:0]      addr_width, addr_width_next;
  logic [WA_W-1:0]      word_addr, word_addr_next;
  logic [WORD_W-1:0]    shift_word, shift_word_next;
  logic [WORD_W-1:0]    running_sum, running_sum_next;
  logic                 finished, finished_next;

  logic [BIT_CNT_W-1:0] aw_ext;
  logic [BIT_CNT_W-1:0] rd_msb;
  logic [WORD_W-1:0]    wa_ext;
  logic [WA_W-1:0]      wa_inc;
  logic [WORD_W-1:0]    shift_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= '0;
      addr_width  <= '0;
      word_addr   <= '0;
      shift_word  <= '0;
      running_sum <= '0;
      finished    <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      addr_width  <= addr_width_next;
      word_addr   <= word_addr_next;
      shift_word  <= shift_word_next;
      running_sum <= running_sum_next;
      finished    <= finished_next;
    end
  end

  assign aw_ext   = BIT_CNT_W'(addr_width);
  assign rd_msb   = (aw_ext - 5'd1) & 5'd15;
  assign wa_ext   = WORD_W'(word_addr);
  assign wa_inc   = word_addr + 1'b1;
  assign shift_in = {shift_word[WORD_W-2:0], data_out_bit};

  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    addr_width_next  = addr_width;
    word_addr_next   = word_addr;
    shift_word_next  = shift_word;
    running_sum_next = running_sum;
    finished_next    = finished;
    res              = '0;

    case (phase)
      PH_IDLE: begin
        if (start_req) begin
          running_sum_next = '0;
          finished_next    = 1'b0;
          addr_width_next  = '0;
          word_addr_next   = '0;
          shift_word_next  = '0;
          phase_next       = PH_SZ_OP;
          bit_count_next   = '0;
          res.chip_select  = 1'b1;
          res.data_in_bit  = opcode_bit('0);
        end
      end
      PH_SZ_OP: begin
        res.chip_select = 1'b1;
        if (bit_count < OPCODE_LAST) begin
          bit_count_next  = bit_count + 1'b1;
          res.data_in_bit = opcode_bit(bit_count + 1'b1);
        end else begin
          phase_next     = PH_SZ_ADDR;
          bit_count_next = 5'd1;
        end
      end
      PH_SZ_ADDR: begin
        // Stop at the dummy zero or at the widest supported address
        if (!data_out_bit || bit_count >= BIT_CNT_W'(MAX_ADDR_BITS)) begin
          addr_width_next = AW_W'(bit_count);
          phase_next      = PH_GAP;
          bit_count_next  = '0;
        end else begin
          bit_count_next  = bit_count + 1'b1;
          res.chip_select = 1'b1;
        end
      end
      PH_GAP: begin
        phase_next      = PH_RD_OP;
        bit_count_next  = '0;
        res.chip_select = 1'b1;
        res.data_in_bit = opcode_bit('0);
      end
      PH_RD_OP: begin
        res.chip_select = 1'b1;
        if (bit_count < OPCODE_LAST) begin
          bit_count_next  = bit_count + 1'b1;
          res.data_in_bit = opcode_bit(bit_count + 1'b1);
        end else begin
          phase_next      = PH_RD_ADDR;
          bit_count_next  = rd_msb;
          res.data_in_bit = wa_ext[rd_msb[3:0]];
        end
      end
      PH_RD_ADDR: begin
        res.chip_select = 1'b1;
        if (bit_count != '0) begin
          bit_count_next  = bit_count - 1'b1;
          res.data_in_bit = wa_ext[4'(bit_count - 1'b1)];
        end else begin
          phase_next      = PH_RD_DATA;
          shift_word_next = '0;
        end
      end
      PH_RD_DATA: begin
        shift_word_next = shift_in;
        if (bit_count < DATA_LAST) begin
          bit_count_next  = bit_count + 1'b1;
          res.chip_select = 1'b1;
        end else begin
          res.word_valid   = 1'b1;
          res.word_index   = INDEX_W'(word_addr);
          res.word_value   = shift_in;
          running_sum_next = running_sum + shift_in;
          word_addr_next   = wa_inc;
          bit_count_next   = '0;
          if (wa_inc >= WA_W'(WORD_COUNT)) begin
            finished_next = 1'b1;
            phase_next    = PH_IDLE;
          end else begin
            phase_next = PH_GAP;
          end
        end
      end
      default: begin
        phase_next     = PH_IDLE;
        bit_count_next = '0;
      end
    endcase

    res.done_res     = finished_next;
    res.checksum_ok  = finished_next && (running_sum_next == checksum_target);
    res.address_bits = ABITS_W'(addr_width_next);
  end

  `MWL_ASSERT(a_word_at_last_bit,
    res.word_valid |-> (phase == PH_RD_DATA) && (bit_count == DATA_LAST),
    "word completed outside the last data bit")
  `MWL_ASSERT(a_addr_count_range,
    (phase == PH_RD_ADDR) |-> !bit_count[BIT_CNT_W-1],
    "address bit counter out of range")
  `MWL_ASSERT_ALWAYS(a_finished_idle,
    finished |-> (phase == PH_IDLE),
    "load marked finished while sequencer busy")

endmodule

### rtl/microwire_eeprom_loader_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Microwire EEPROM loader
// Steps a Microwire serial EEPROM one period per request and unloads it.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on s_axis is one serial clock period: it carries start_req
//   and the EEPROM data-out level sampled in the period driven by the last
//   result. Every request yields exactly one result on m_axis with chip
//   select and data-in for the next period, plus the word, done and
//   checksum status.
//   Each result is registered: a request taken is offered as a result in the
//   cycle after. One request is taken per cycle unless m_axis back-pressure
//   holds the result register; the sequencer does a fixed amount of work per period.
//   The result register holds while m_axis_tready is low; s_axis_tready
//   stays high as long as that register is empty or is being drained.
//   Reset idles the sequencer, clears the sum, width and done flag, empties
//   the result register and loads the checksum target with 0xBABA.
//   Write cfg_wdata with cfg_we only while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module microwire_eeprom_loader_unit #(
  parameter int WORD_COUNT    = mwl_pkg::DEF_WORD_COUNT,
  parameter int MAX_ADDR_BITS = mwl_pkg::DEF_MAX_ADDR_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [0] start_req, [1] data_out_bit, [7:2] zero
  input  logic [7:0]                 s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [0] chip_select, [1] data_in_bit, [2] word_valid, [8:3] word_index,
  // [24:9] word_value, [25] done_res, [26] checksum_ok, [30:27] address_bits,
  // [31] zero
  output logic [31:0]                m_axis_tdata,
  input  logic                       cfg_we,
  input  logic [mwl_pkg::WORD_W-1:0] cfg_wdata
);
  import mwl_pkg::*;

  logic [WORD_W-1:0] checksum_target;
  logic              out_valid;
  result_t           out_data;
  result_t           seq_res;
  logic              accept;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum_target <= CHECKSUM_RESET;
    end else if (cfg_we) begin
      checksum_target <= cfg_wdata;
    end
  end

  mwl_seq #(
    .WORD_COUNT    (WORD_COUNT),
    .MAX_ADDR_BITS (MAX_ADDR_BITS)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .step            (accept),
    .start_req       (s_axis_tdata[0]),
    .data_out_bit    (s_axis_tdata[1]),
    .checksum_target (checksum_target),
    .res             (seq_res)
  );

  // Result register: load on a request, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= seq_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_data};

  `MWL_ASSERT(a_accept_fills,
    accept |=> m_axis_tvalid,
    "request taken but no result offered")
  `MWL_ASSERT(a_di_needs_cs,
    (m_axis_tvalid && !m_axis_tdata[0]) |-> !m_axis_tdata[1],
    "data-in driven with chip select low")
  `MWL_ASSERT(a_ok_needs_done,
    (m_axis_tvalid && m_axis_tdata[26]) |-> m_axis_tdata[25],
    "checksum status without done")

endmodule
